FILE: src/rrts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types and fixed field widths for the round-robin scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

	localparam int SVC_W    = 16;
	localparam int ID_OUT_W = 4;
	localparam int TOUT_W   = 16;
	localparam int QLEN_W   = 5;
	localparam int CFG_W    = 8;

	typedef enum logic {
		OP_ARRIVE = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	// per-cell control: shift toward head, load pushed entry, rewrite head
	typedef struct packed {
		logic pop;
		logic load;
		logic hwr;
	} cell_ctl_t;

endpackage

FILE: src/rrts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts interfaces
// Valid/ready channels for items, results and the quantum register.
// ----------------------------------------------------------------------------
interface rrts_req_if;
	logic                      valid;
	logic                      ready;
	logic                      opcode;
	logic [rrts_pkg::SVC_W-1:0] svc_time;

	modport source (output valid, output opcode, output svc_time, input ready);
	modport sink (input valid, input opcode, input svc_time, output ready);
endinterface

interface rrts_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic                        accepted;
	logic [rrts_pkg::ID_OUT_W-1:0] task_id;
	logic                        busy_res;
	logic                        finished;
	logic                        preempted;
	logic [rrts_pkg::TOUT_W-1:0] finish_time;
	logic [rrts_pkg::TOUT_W-1:0] turnaround;
	logic [rrts_pkg::QLEN_W-1:0] queue_length;

	modport source (output valid, output kind, output accepted, output task_id,
		output busy_res, output finished, output preempted, output finish_time,
		output turnaround, output queue_length, input ready);
	modport sink (input valid, input kind, input accepted, input task_id,
		input busy_res, input finished, input preempted, input finish_time,
		input turnaround, input queue_length, output ready);
endinterface

interface rrts_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [rrts_pkg::CFG_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/round_robin_time_slice_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_time_slice_scheduler
// Round-robin time-slice scheduler over a shifting chain of queue cells.
// ----------------------------------------------------------------------------
// the result of an item is registered as the item is taken
// throughput: one item per cycle while each result is taken; the cell chain updates once per item
// the item port stays open while a result waits, as long as the result is taken
// reset: queue empty, time and ids zero, quantum 1; queue cells and arrival table need no clearing
module round_robin_time_slice_scheduler #(
	parameter int MAX_TASKS    = 16,
	parameter int TIME_BITS    = 16,
	parameter int QUANTUM_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	rrts_req_if.sink   req,
	rrts_rsp_if.source rsp,
	rrts_cfg_if.sink   cfg
);
	import rrts_pkg::*;

	localparam int IDW  = $clog2(MAX_TASKS);
	localparam int CNTW = $clog2(MAX_TASKS + 1);
	localparam int W    = IDW + SVC_W;

	// cell word: {id, remaining}
	logic [W-1:0]  link [MAX_TASKS+1];
	cell_ctl_t     ctl [MAX_TASKS];
	logic [W-1:0]  push_w;
	logic [W-1:0]  head_w;

	// arrival time per task id
	logic [TIME_BITS-1:0]    arr_q [MAX_TASKS];

	logic [CFG_W-1:0]        quantum_q;
	logic [QUANTUM_BITS-1:0] qleft_q;
	logic [CNTW-1:0]         count_q;
	logic                    pend_q;
	logic [W-1:0]            reqe_q;
	logic [IDW-1:0]          next_id_q;
	logic [TIME_BITS-1:0]    now_q;

	logic                    vld_q;
	logic                    kind_q;
	logic                    acc_q;
	logic [ID_OUT_W-1:0]     tid_q;
	logic                    busy_q;
	logic                    fin_q;
	logic                    pre_q;
	logic [TOUT_W-1:0]       ftime_q;
	logic [TOUT_W-1:0]       tat_q;
	logic [QLEN_W-1:0]       qlen_q;

	logic                    take;
	logic                    is_tick;
	logic [CNTW:0]           occupied;
	logic                    room;
	logic [CNTW-1:0]         cnt1;
	logic                    run;
	logic [IDW-1:0]          h_id;
	logic [SVC_W-1:0]        h_rem;
	logic                    done;
	logic                    qdone;
	logic [SVC_W-1:0]        rem_nx;
	logic                    pop;
	logic                    push_en;
	logic [CNTW-1:0]         cnt_nx;
	logic                    pend_nx;
	logic [TIME_BITS-1:0]    fin_t;
	logic [CFG_W+QUANTUM_BITS-1:0] qwide;
	logic [QUANTUM_BITS-1:0] qmask;
	logic [QUANTUM_BITS-1:0] qload;
	logic [CFG_W+QUANTUM_BITS-1:0] cwide;
	logic [QUANTUM_BITS-1:0] cmask;
	logic [QUANTUM_BITS-1:0] cload;
	logic [TIME_BITS+TOUT_W-1:0] fwide;
	logic [IDW+ID_OUT_W-1:0] iwide;
	logic [IDW+ID_OUT_W-1:0] awide;
	logic [CNTW+QLEN_W:0]    lwide;

	assign req.ready = !vld_q || rsp.ready;
	assign cfg.ready = 1'b1;
	assign take      = req.valid && req.ready;
	assign is_tick   = (op_t'(req.opcode) == OP_TICK);

	// quantum of zero behaves as one
	assign qwide = {{QUANTUM_BITS{1'b0}}, quantum_q};
	assign qmask = qwide[QUANTUM_BITS-1:0];
	assign qload = (qmask == '0) ? QUANTUM_BITS'(1) : qmask;
	assign cwide = {{QUANTUM_BITS{1'b0}}, cfg.data};
	assign cmask = cwide[QUANTUM_BITS-1:0];
	assign cload = (cmask == '0) ? QUANTUM_BITS'(1) : cmask;

	assign occupied = {1'b0, count_q} + (CNTW+1)'(pend_q);
	assign room     = occupied < (CNTW+1)'(MAX_TASKS);
	assign cnt1     = occupied[CNTW-1:0];

	// head after a pending requeue has been appended
	assign head_w = link[0];
	assign h_id   = head_w[W-1 -: IDW];
	assign h_rem  = head_w[SVC_W-1:0];

	assign run    = is_tick && (cnt1 != '0);
	assign done   = h_rem <= SVC_W'(1);
	assign qdone  = qleft_q <= QUANTUM_BITS'(1);
	assign rem_nx = done ? '0 : h_rem - SVC_W'(1);
	assign pop    = run && (done || qdone);

	assign push_en = is_tick ? pend_q : room;
	assign push_w  = is_tick ? reqe_q : {next_id_q, req.svc_time};

	always_comb begin
		if (is_tick) begin
			cnt_nx  = cnt1 - CNTW'(pop);
			pend_nx = run && qdone && !done;
		end else begin
			cnt_nx  = count_q + CNTW'(room);
			pend_nx = pend_q;
		end
	end

	assign fin_t = now_q + TIME_BITS'(1);
	assign fwide = {{TOUT_W{1'b0}}, fin_t};
	assign iwide = {{ID_OUT_W{1'b0}}, h_id};
	assign awide = {{ID_OUT_W{1'b0}}, next_id_q};
	assign lwide = {{QLEN_W{1'b0}}, cnt_nx} + (CNTW+QLEN_W+1)'(pend_nx);

	genvar gi;
	generate
		for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
			always_comb begin
				ctl[gi].pop  = take && pop;
				ctl[gi].load = take && push_en && (count_q == CNTW'(gi));
				ctl[gi].hwr  = take && run && !pop && (gi == 0);
			end

			rrts_cell #(
				.W(W)
			) u_cell (
				.clk    (clk),
				.ctl    (ctl[gi]),
				.push_d (push_w),
				.head_d ({h_id, rem_nx}),
				.up_d   (link[gi+1]),
				.dn_d   (link[gi])
			);
		end
	endgenerate

	assign link[MAX_TASKS] = '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= CFG_W'(1);
			qleft_q   <= QUANTUM_BITS'(1);
			count_q   <= '0;
			pend_q    <= 1'b0;
			next_id_q <= '0;
			now_q     <= '0;
			vld_q     <= 1'b0;
		end else begin
			if (take) begin
				vld_q <= 1'b1;
			end else if (rsp.ready) begin
				vld_q <= 1'b0;
			end
			if (take) begin
				count_q <= cnt_nx;
				pend_q  <= pend_nx;
				if (is_tick) begin
					now_q <= fin_t;
				end else if (room) begin
					next_id_q <= (next_id_q == IDW'(MAX_TASKS - 1)) ? '0
						: next_id_q + IDW'(1);
				end
			end
			if (cfg.valid) begin
				quantum_q <= cfg.data;
				qleft_q   <= cload;
			end else if (take && run) begin
				qleft_q <= pop ? qload : qleft_q - QUANTUM_BITS'(1);
			end
		end
	end

	// result register and preempted task hold
	always_ff @(posedge clk) begin
		if (take) begin
			kind_q  <= is_tick;
			acc_q   <= !is_tick && room;
			busy_q  <= run;
			fin_q   <= run && done;
			pre_q   <= run && qdone && !done;
			qlen_q  <= lwide[QLEN_W-1:0];
			ftime_q <= (run && done) ? fwide[TOUT_W-1:0] : '0;
			tat_q   <= (run && done) ? TOUT_W'(fin_t - arr_q[h_id]) : '0;
			if (is_tick) begin
				tid_q <= run ? iwide[ID_OUT_W-1:0] : '0;
			end else begin
				tid_q <= room ? awide[ID_OUT_W-1:0] : '0;
			end
			if (!is_tick && room) begin
				arr_q[next_id_q] <= now_q;
			end
			if (run && qdone && !done) begin
				reqe_q <= {h_id, rem_nx};
			end
		end
	end

	assign rsp.valid        = vld_q;
	assign rsp.kind         = kind_q;
	assign rsp.accepted     = acc_q;
	assign rsp.task_id      = tid_q;
	assign rsp.busy_res     = busy_q;
	assign rsp.finished     = fin_q;
	assign rsp.preempted    = pre_q;
	assign rsp.finish_time  = ftime_q;
	assign rsp.turnaround   = tat_q;
	assign rsp.queue_length = qlen_q;

endmodule

FILE: src/rrts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrts_cell
// One ready-queue slot; shifts toward the head on a pop.
// ----------------------------------------------------------------------------
module rrts_cell #(
	parameter int W = 40
) (
	input  logic               clk,
	input  rrts_pkg::cell_ctl_t ctl,
	input  logic [W-1:0]       push_d,
	input  logic [W-1:0]       head_d,
	input  logic [W-1:0]       up_d,
	output logic [W-1:0]       dn_d
);
	import rrts_pkg::*;

	logic [W-1:0] slot_q;

	// contents after a possible push, handed to the neighbor nearer the head
	assign dn_d = ctl.load ? push_d : slot_q;

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			slot_q <= up_d;
		end else if (ctl.hwr) begin
			slot_q <= head_d;
		end else begin
			slot_q <= dn_d;
		end
	end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the round-robin time-slice scheduler. A queue of
// arrive/tick transactions is driven under several quantum settings and idle
// patterns. A transaction-level scheduler model predicts each result, and every
// received result is compared field by field against it.
// ----------------------------------------------------------------------------
module tb;
	import rrts_pkg::*;

	localparam int DEPTH       = 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PRINT_LIMIT = 50;

	typedef struct {
		op_t              op;
		logic [SVC_W-1:0] svc;
	} sched_item_t;

	typedef struct packed {
		logic                kind;
		logic                accepted;
		logic [ID_OUT_W-1:0] task_id;
		logic                busy_res;
		logic                finished;
		logic                preempted;
		logic [TOUT_W-1:0]   finish_time;
		logic [TOUT_W-1:0]   turnaround;
		logic [QLEN_W-1:0]   queue_length;
	} sched_result_t;

	logic clk;
	logic arst_n;

	rrts_req_if req();
	rrts_rsp_if rsp();
	rrts_cfg_if cfg();

	round_robin_time_slice_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	sched_item_t   task_requests[$];
	sched_result_t expected_results[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;

	int unsigned cycle_count     = 0;
	int unsigned error_count     = 0;
	int unsigned results_checked = 0;
	int unsigned finish_count    = 0;
	int unsigned preempt_count   = 0;
	int unsigned reject_count    = 0;
	int unsigned idle_tick_count = 0;
	int unsigned wrap_finishes   = 0;

	// scheduler model state
	logic [ID_OUT_W-1:0] fifo_id [DEPTH];
	logic [SVC_W-1:0]    fifo_rem [DEPTH];
	logic [TOUT_W-1:0]   arrival_time [DEPTH];
	logic [3:0]          q_head;
	logic [3:0]          q_tail;
	int                  q_count;
	logic [CFG_W-1:0]    quantum_reg;
	logic [CFG_W-1:0]    slice_left;
	logic                requeue_valid;
	logic [ID_OUT_W-1:0] requeue_id;
	logic [SVC_W-1:0]    requeue_rem;
	logic [ID_OUT_W-1:0] id_counter;
	logic [TOUT_W-1:0]   clock_now;

	function automatic logic [CFG_W-1:0] slice_reload();
		return (quantum_reg == '0) ? CFG_W'(1) : quantum_reg;
	endfunction

	function automatic void fifo_push(logic [ID_OUT_W-1:0] id, logic [SVC_W-1:0] rem);
		fifo_id[q_tail]  = id;
		fifo_rem[q_tail] = rem;
		q_tail           = q_tail + 4'd1;
		q_count++;
	endfunction

	function automatic sched_result_t schedule_step(op_t op, logic [SVC_W-1:0] svc);
		sched_result_t       r;
		logic [ID_OUT_W-1:0] id;
		logic [TOUT_W-1:0]   fin;
		logic                done;
		logic                slice_done;
		r = '0;
		if (op == OP_ARRIVE) begin
			// a pending requeue counts against the free slots
			if (q_count + int'(requeue_valid) < DEPTH) begin
				arrival_time[id_counter] = clock_now;
				fifo_push(id_counter, svc);
				r.accepted   = 1'b1;
				r.task_id    = id_counter;
				id_counter   = id_counter + 1'b1;
			end
		end else begin
			r.kind = 1'b1;
			if (requeue_valid) begin
				fifo_push(requeue_id, requeue_rem);
				requeue_valid = 1'b0;
			end
			if (q_count > 0) begin
				id         = fifo_id[q_head];
				done       = fifo_rem[q_head] <= 1;
				slice_done = slice_left <= 1;
				r.task_id  = id;
				r.busy_res = 1'b1;
				fifo_rem[q_head] = done ? '0 : fifo_rem[q_head] - 1'b1;
				slice_left       = slice_done ? '0 : slice_left - 1'b1;
				if (done) begin
					fin           = clock_now + 1'b1;
					r.finished    = 1'b1;
					r.finish_time = fin;
					r.turnaround  = fin - arrival_time[id];
					q_head        = q_head + 4'd1;
					q_count--;
					slice_left    = slice_reload();
				end else if (slice_done) begin
					r.preempted   = 1'b1;
					requeue_id    = id;
					requeue_rem   = fifo_rem[q_head];
					requeue_valid = 1'b1;
					q_head        = q_head + 4'd1;
					q_count--;
					slice_left    = slice_reload();
				end
			end
			clock_now = clock_now + 1'b1;
		end
		r.queue_length = QLEN_W'(q_count + int'(requeue_valid));
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT)
			$display("mismatch at result %0d: %s", results_checked, msg);
	endtask

	task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// driver: next transaction once the current one is taken
	always @(posedge clk) begin : driver
		sched_item_t next_req;
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (!req.valid || req.ready) begin
			if (task_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req     = task_requests.pop_front();
				req.valid    <= 1'b1;
				req.opcode   <= next_req.op;
				req.svc_time <= next_req.svc;
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: model update on accepted transactions, result check
	always @(posedge clk) begin : monitor
		sched_result_t got;
		sched_result_t want;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				quantum_reg = cfg.data;
				slice_left  = slice_reload();
			end
			if (req.valid && req.ready)
				expected_results.insert(expected_results.size(),
					schedule_step(op_t'(req.opcode), req.svc_time));
			if (rsp.valid && rsp.ready) begin
				got.kind         = rsp.kind;
				got.accepted     = rsp.accepted;
				got.task_id      = rsp.task_id;
				got.busy_res     = rsp.busy_res;
				got.finished     = rsp.finished;
				got.preempted    = rsp.preempted;
				got.finish_time  = rsp.finish_time;
				got.turnaround   = rsp.turnaround;
				got.queue_length = rsp.queue_length;
				if (expected_results.size() == 0) begin
					report_mismatch("result with no transaction waiting");
				end else begin
					want = expected_results.pop_front();
					check_field("kind", 16'(got.kind), 16'(want.kind));
					check_field("accepted", 16'(got.accepted), 16'(want.accepted));
					check_field("task_id", 16'(got.task_id), 16'(want.task_id));
					check_field("busy_res", 16'(got.busy_res), 16'(want.busy_res));
					check_field("finished", 16'(got.finished), 16'(want.finished));
					check_field("preempted", 16'(got.preempted), 16'(want.preempted));
					check_field("finish_time", got.finish_time, want.finish_time);
					check_field("turnaround", got.turnaround, want.turnaround);
					check_field("queue_length", 16'(got.queue_length),
						16'(want.queue_length));
					if (want.finished) finish_count++;
					if (want.finished && want.turnaround > want.finish_time) wrap_finishes++;
					if (want.preempted) preempt_count++;
					if (!want.kind && !want.accepted) reject_count++;
					if (want.kind && !want.busy_res) idle_tick_count++;
				end
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL round_robin_time_slice_scheduler");
			$finish;
		end
	end

	task automatic add_item(op_t op, logic [SVC_W-1:0] svc);
		sched_item_t it;
		it.op  = op;
		it.svc = svc;
		task_requests.insert(task_requests.size(), it);
	endtask

	// wait until every transaction is taken and answered
	task automatic wait_idle();
		do @(negedge clk);
		while (task_requests.size() != 0 || req.valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_quantum(logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data  <= value;
		do @(posedge clk);
		while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [SVC_W-1:0] pick_service(bit long_tasks);
		int unsigned r;
		r = $urandom_range(99);
		if (long_tasks && r >= 85) return SVC_W'($urandom_range(65535, 0));
		if (r < 70) return SVC_W'($urandom_range(8, 1));
		if (r < 92) return SVC_W'($urandom_range(300, 9));
		if (r < 96) return '0;
		return SVC_W'(1);
	endfunction

	// bursts of mostly-arrive, mixed or mostly-tick traffic
	task automatic queue_random(int n, bit long_tasks);
		int burst_left;
		int arrive_pct;
		burst_left = 0;
		arrive_pct = 50;
		for (int i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(20, 1);
				case ($urandom_range(2))
					0: arrive_pct = 10;
					1: arrive_pct = 50;
					default: arrive_pct = 90;
				endcase
			end
			burst_left--;
			if ($urandom_range(99) < arrive_pct)
				add_item(OP_ARRIVE, pick_service(long_tasks));
			else
				add_item(OP_TICK, SVC_W'($urandom_range(65535, 0)));
		end
	endtask

	task automatic set_idling(int send_pct, int stall_pct);
		send_idle_pct  = send_pct;
		recv_stall_pct = stall_pct;
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg.valid        = 1'b0;
		cfg.data         = '0;

		q_head        = '0;
		q_tail        = '0;
		q_count       = 0;
		quantum_reg   = CFG_W'(1);
		slice_left    = CFG_W'(1);
		requeue_valid = 1'b0;
		requeue_id    = '0;
		requeue_rem   = '0;
		id_counter    = '0;
		clock_now     = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle tick, zero and unit service, longest service, preemption at quantum 1
		add_item(OP_TICK, '0);
		add_item(OP_ARRIVE, '0);
		add_item(OP_ARRIVE, SVC_W'(1));
		add_item(OP_ARRIVE, '1);
		repeat (4) add_item(OP_TICK, '1);
		wait_idle();

		// fill up while a requeue is pending, so the last arrives are rejected
		write_quantum(CFG_W'(2));
		for (int i = 0; i < 17; i++) add_item(OP_ARRIVE, SVC_W'(i % 3 + 1));
		wait_idle();

		set_idling(0, 0);
		write_quantum('1);
		queue_random(200, 1'b0);
		wait_idle();

		set_idling(67, 0);
		write_quantum(CFG_W'(3));
		queue_random(200, 1'b0);
		wait_idle();

		// quantum of zero behaves as one
		set_idling(0, 67);
		write_quantum('0);
		queue_random(200, 1'b0);
		wait_idle();

		set_idling(8, 8);
		write_quantum(CFG_W'($urandom_range(255, 1)));
		queue_random(200, 1'b0);
		wait_idle();

		set_idling(0, 0);
		write_quantum(CFG_W'(1));
		queue_random(200, 1'b0);
		wait_idle();

		set_idling(8, 8);
		write_quantum(CFG_W'($urandom_range(255, 1)));
		queue_random(200, 1'b1);
		wait_idle();

		$display("checked %0d results: %0d finishes (%0d across the time wrap), %0d preemptions",
			results_checked, finish_count, wrap_finishes, preempt_count);
		$display("%0d arrives rejected on a full queue, %0d idle ticks, %0d mismatches",
			reject_count, idle_tick_count, error_count);
		if (error_count == 0) begin
			$display("PASS round_robin_time_slice_scheduler");
		end else begin
			$display("FAIL round_robin_time_slice_scheduler");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/rrts_pkg.sv
src/rrts_if.sv
src/rrts_cell.sv
src/round_robin_time_slice_scheduler.sv
sim/tb.sv
